### rtl/spq_pkg.sv
// Package for the stable priority queue.
// Holds the record type, cell control type and opcode/status codes.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int unsigned URG_W = 4;
    localparam int unsigned ID_W  = 54;
    localparam int unsigned AGE_W = 8;

    localparam int unsigned MIN_W       = 8;
    localparam logic [MIN_W-1:0] MINUTES_RESET = 8'd15;

    localparam int unsigned PLACE_W = 4;
    localparam int unsigned WAIT_W  = 12;
    localparam int unsigned OCC_W   = 5;
    localparam int unsigned STAT_W  = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [URG_W-1:0] urgency;
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
    } t_rec;

    typedef struct packed {
        logic ins;
        logic pop;
        logic occupied;
    } t_cell_ctl;

endpackage

### rtl/spq_cell.sv
// One slot of the sorted queue: holds a record, compares it to the new one,
// and shifts with its neighbors on insert or pop. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_rec     i_new_rec,
    input  spq_pkg::t_rec     i_left_rec,
    input  logic              i_left_le,
    input  spq_pkg::t_rec     i_right_rec,
    output spq_pkg::t_rec     o_rec,
    output logic              o_le
);

    spq_pkg::t_rec r_rec;
    spq_pkg::t_rec n_rec;

    // stored record sorts at or before the new one
    assign o_le  = i_ctl.occupied && (r_rec.urgency <= i_new_rec.urgency);
    assign o_rec = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.ins && !o_le) begin
            n_rec = i_left_le ? i_new_rec : i_left_rec;
        end else if (i_ctl.pop) begin
            n_rec = i_right_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

### rtl/stable_priority_queue.sv
// Stable priority queue: a row of spq_cell slots kept sorted by urgency.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low; busy is
//   always low, so one request may be issued every cycle. i_func selects
//   insert or pop of the head record.
//   The result appears in the cycle after the request, for exactly one cycle,
//   with o_valid high. The receiver cannot stall; results are not held.
//   Throughput: 1 request per cycle, set by the cell row which compares and
//   shifts every slot in the same cycle.
//   Insert reports the place taken and place * minutes_per_place (saturated
//   at 4095). Pop reports the head record. Insert into a full queue and pop
//   from an empty one report a status code and leave the queue unchanged.
//   minutes_per_place is written with i_cfg_wr_en / i_cfg_wr_data while idle.
//   Synchronous reset empties the queue and sets minutes_per_place to 15;
//   no clearing pass is needed.
`timescale 1ns / 1ps

module stable_priority_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [spq_pkg::URG_W-1:0]     i_urgency,
    input  logic [spq_pkg::ID_W-1:0]      i_record_id,
    input  logic [spq_pkg::AGE_W-1:0]     i_record_age,
    input  logic                          i_cfg_wr_en,
    input  logic [spq_pkg::MIN_W-1:0]     i_cfg_wr_data,
    output logic                          o_valid,
    output logic [spq_pkg::STAT_W-1:0]    o_status,
    output logic [spq_pkg::PLACE_W-1:0]   o_place,
    output logic [spq_pkg::WAIT_W-1:0]    o_wait_estimate,
    output logic [spq_pkg::URG_W-1:0]     o_head_urgency,
    output logic [spq_pkg::ID_W-1:0]      o_head_id,
    output logic [spq_pkg::AGE_W-1:0]     o_head_age,
    output logic [spq_pkg::OCC_W-1:0]     o_occupancy
);

    localparam int unsigned PW  = $clog2(DEPTH);
    localparam int unsigned CW  = $clog2(DEPTH + 1);
    localparam int unsigned PRW = PW + spq_pkg::MIN_W;
    localparam int unsigned WW  = (PRW > spq_pkg::WAIT_W) ? PRW : spq_pkg::WAIT_W;
    localparam int unsigned EPW = (PW > spq_pkg::PLACE_W) ? PW : spq_pkg::PLACE_W;
    localparam int unsigned ECW = (CW > spq_pkg::OCC_W) ? CW : spq_pkg::OCC_W;
    localparam logic [WW-1:0] WAIT_MAX = WW'({spq_pkg::WAIT_W{1'b1}});

    logic [spq_pkg::MIN_W-1:0] r_minutes;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      do_ins;
    logic                      do_pop;

    spq_pkg::t_rec             new_rec;
    spq_pkg::t_rec             cell_rec [DEPTH];
    logic [DEPTH-1:0]          cell_le;
    logic [DEPTH-1:0]          bnd;
    logic [PW-1:0]             place;
    logic [PRW-1:0]            product;
    logic [WW-1:0]             wait_ext;
    logic [EPW-1:0]            place_ext;
    logic [ECW-1:0]            count_ext;

    logic                          r_valid;
    spq_pkg::t_status              r_status;
    logic [spq_pkg::PLACE_W-1:0]   r_place;
    logic [spq_pkg::WAIT_W-1:0]    r_wait;
    spq_pkg::t_rec                 r_head;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign do_ins  = accept && (i_func == spq_pkg::FUNC_INSERT) && !full;
    assign do_pop  = accept && (i_func == spq_pkg::FUNC_POP) && !empty;

    assign new_rec.urgency = i_urgency;
    assign new_rec.id      = i_record_id;
    assign new_rec.age     = i_record_age;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        spq_pkg::t_cell_ctl ctl;
        spq_pkg::t_rec      left_rec;
        spq_pkg::t_rec      right_rec;
        logic               left_le;

        assign ctl.ins      = do_ins;
        assign ctl.pop      = do_pop;
        assign ctl.occupied = (CW'(gi) < r_count);

        if (gi == 0) begin : g_first
            assign left_rec = new_rec;
            assign left_le  = 1'b1;
        end else begin : g_mid
            assign left_rec = cell_rec[gi-1];
            assign left_le  = cell_le[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign right_rec = cell_rec[gi];
        end else begin : g_inner
            assign right_rec = cell_rec[gi+1];
        end

        // new record lands here
        assign bnd[gi] = !cell_le[gi] && left_le;

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_new_rec   (new_rec),
            .i_left_rec  (left_rec),
            .i_left_le   (left_le),
            .i_right_rec (right_rec),
            .o_rec       (cell_rec[gi]),
            .o_le        (cell_le[gi])
        );
    end

    always_comb begin
        place = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (bnd[i]) begin
                place = place | PW'(i);
            end
        end
    end

    assign product   = PRW'(place) * PRW'(r_minutes);
    assign wait_ext  = WW'(product);
    assign place_ext = EPW'(place);

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minutes <= spq_pkg::MINUTES_RESET;
            r_count   <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_minutes <= i_cfg_wr_data;
            end
            r_count <= n_count;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= spq_pkg::ST_DONE;
            r_place  <= '0;
            r_wait   <= '0;
            r_head   <= '0;
            if (i_func == spq_pkg::FUNC_INSERT) begin
                if (full) begin
                    r_status <= spq_pkg::ST_FULL;
                end else begin
                    r_place <= place_ext[spq_pkg::PLACE_W-1:0];
                    r_wait  <= (wait_ext > WAIT_MAX) ? spq_pkg::WAIT_W'(WAIT_MAX)
                                                     : wait_ext[spq_pkg::WAIT_W-1:0];
                end
            end else begin
                if (empty) begin
                    r_status <= spq_pkg::ST_EMPTY;
                end else begin
                    r_head <= cell_rec[0];
                end
            end
        end
    end

    assign count_ext       = ECW'(r_count);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_place         = r_place;
    assign o_wait_estimate = r_wait;
    assign o_head_urgency  = r_head.urgency;
    assign o_head_id       = r_head.id;
    assign o_head_age      = r_head.age;
    assign o_occupancy     = count_ext[spq_pkg::OCC_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    a_one_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |-> $onehot(bnd))
        else $error("insert position not unique");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == spq_pkg::FUNC_INSERT && full) |=>
            (r_status == spq_pkg::ST_FULL) && (r_count == CW'(DEPTH)))
        else $error("insert into full queue changed state");

    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == spq_pkg::FUNC_POP && empty) |=>
            (r_status == spq_pkg::ST_EMPTY) && (r_count == '0))
        else $error("pop from empty queue changed state");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> (r_count == $past(r_count)) && !r_valid)
        else $error("count moved without a request");

endmodule

### tb/tb_top.sv
// Self-checking testbench for stable_priority_queue: directed and random insert/pop
// requests, checked result by result against a shadow copy of the sorted record row.
// Depends on spq_pkg and the stable_priority_queue RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = 16;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RAND_PER_PH = 120;
    localparam logic [spq_pkg::ID_W-1:0] ID_MAX = 54'd9999999999999999;

    typedef struct packed {
        logic                      func;
        logic [spq_pkg::URG_W-1:0] urgency;
        logic [spq_pkg::ID_W-1:0]  id;
        logic [spq_pkg::AGE_W-1:0] age;
    } t_queue_req;

    typedef struct packed {
        spq_pkg::t_status            status;
        logic [spq_pkg::PLACE_W-1:0] place;
        logic [spq_pkg::WAIT_W-1:0]  wait_estimate;
        logic [spq_pkg::URG_W-1:0]   head_urgency;
        logic [spq_pkg::ID_W-1:0]    head_id;
        logic [spq_pkg::AGE_W-1:0]   head_age;
        logic [spq_pkg::OCC_W-1:0]   occupancy;
    } t_queue_res;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_func = spq_pkg::FUNC_INSERT;
    logic [spq_pkg::URG_W-1:0]     i_urgency = '0;
    logic [spq_pkg::ID_W-1:0]      i_record_id = '0;
    logic [spq_pkg::AGE_W-1:0]     i_record_age = '0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [spq_pkg::MIN_W-1:0]     i_cfg_wr_data = '0;
    logic                          o_valid;
    logic [spq_pkg::STAT_W-1:0]    o_status;
    logic [spq_pkg::PLACE_W-1:0]   o_place;
    logic [spq_pkg::WAIT_W-1:0]    o_wait_estimate;
    logic [spq_pkg::URG_W-1:0]     o_head_urgency;
    logic [spq_pkg::ID_W-1:0]      o_head_id;
    logic [spq_pkg::AGE_W-1:0]     o_head_age;
    logic [spq_pkg::OCC_W-1:0]     o_occupancy;

    stable_priority_queue #(.DEPTH(DEPTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_urgency      (i_urgency),
        .i_record_id    (i_record_id),
        .i_record_age   (i_record_age),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_place        (o_place),
        .o_wait_estimate(o_wait_estimate),
        .o_head_urgency (o_head_urgency),
        .o_head_id      (o_head_id),
        .o_head_age     (o_head_age),
        .o_occupancy    (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_queue_req request_queue[$];
    t_queue_res expected_results[$];

    // shadow of the record row, slot 0 is the head
    logic [spq_pkg::URG_W-1:0] shadow_urg [DEPTH];
    logic [spq_pkg::ID_W-1:0]  shadow_id  [DEPTH];
    logic [spq_pkg::AGE_W-1:0] shadow_age [DEPTH];
    int               shadow_held = 0;
    int unsigned      shadow_minutes = spq_pkg::MINUTES_RESET;

    int unsigned gap_pct = 0;
    int unsigned error_count = 0;
    int unsigned requests_taken = 0;
    int unsigned results_checked = 0;
    int unsigned insert_count = 0;
    int unsigned pop_count = 0;
    int unsigned full_count = 0;
    int unsigned empty_count = 0;
    int unsigned max_held = 0;
    int unsigned idle_cycles = 0;

    function automatic logic [spq_pkg::ID_W-1:0] rand_id();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ID_MAX;
            2: return {1'b1, {(spq_pkg::ID_W-1){1'b0}}};
            default: return (raw[spq_pkg::ID_W-1:0] > ID_MAX)
                            ? raw[spq_pkg::ID_W-1:0] % (ID_MAX + 1)
                            : raw[spq_pkg::ID_W-1:0];
        endcase
    endfunction

    function automatic t_queue_req make_insert(input int unsigned urg,
                                               input logic [spq_pkg::ID_W-1:0] id,
                                               input int unsigned age);
        t_queue_req r;
        r.func    = spq_pkg::FUNC_INSERT;
        r.urgency = urg[spq_pkg::URG_W-1:0];
        r.id      = id;
        r.age     = age[spq_pkg::AGE_W-1:0];
        return r;
    endfunction

    task automatic apply_request(input t_queue_req r);
        t_queue_res  res;
        int          pos;
        int unsigned wait_min;
        res = '0;
        if (r.func == spq_pkg::FUNC_INSERT) begin
            insert_count++;
            if (shadow_held >= DEPTH) begin
                res.status = spq_pkg::ST_FULL;
                full_count++;
            end else begin
                pos = 0;
                while (pos < shadow_held && shadow_urg[pos] <= r.urgency) pos++;
                for (int i = shadow_held; i > pos; i--) begin
                    shadow_urg[i] = shadow_urg[i-1];
                    shadow_id[i]  = shadow_id[i-1];
                    shadow_age[i] = shadow_age[i-1];
                end
                shadow_urg[pos] = r.urgency;
                shadow_id[pos]  = r.id;
                shadow_age[pos] = r.age;
                shadow_held++;
                wait_min = pos * shadow_minutes;
                if (wait_min > 4095) wait_min = 4095;
                res.status        = spq_pkg::ST_DONE;
                res.place         = pos[spq_pkg::PLACE_W-1:0];
                res.wait_estimate = wait_min[spq_pkg::WAIT_W-1:0];
            end
        end else begin
            pop_count++;
            if (shadow_held == 0) begin
                res.status = spq_pkg::ST_EMPTY;
                empty_count++;
            end else begin
                res.status       = spq_pkg::ST_DONE;
                res.head_urgency = shadow_urg[0];
                res.head_id      = shadow_id[0];
                res.head_age     = shadow_age[0];
                for (int i = 0; i + 1 < shadow_held; i++) begin
                    shadow_urg[i] = shadow_urg[i+1];
                    shadow_id[i]  = shadow_id[i+1];
                    shadow_age[i] = shadow_age[i+1];
                end
                shadow_held--;
            end
        end
        if (shadow_held > max_held) max_held = shadow_held;
        res.occupancy = shadow_held[spq_pkg::OCC_W-1:0];
        expected_results.push_back(res);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        $display("MISMATCH %s: expected %0d got %0d (result %0d, t=%0t)",
                 what, want, got, results_checked, $realtime);
        error_count++;
    endtask

    task automatic write_minutes(input logic [spq_pkg::MIN_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        shadow_minutes = value;
    endtask

    // driver: request taken at an edge with start high and busy low
    always @(posedge i_clk) begin
        logic held_off;
        held_off = start && busy;
        if (i_rst_n && start && !busy) begin
            apply_request(request_queue.pop_front());
            requests_taken++;
        end
        if (held_off) begin
            start <= 1'b1;
        end else if (i_rst_n && request_queue.size() > 0
                     && $urandom_range(0, 99) >= gap_pct) begin
            start        <= 1'b1;
            i_func       <= request_queue[0].func;
            i_urgency    <= request_queue[0].urgency;
            i_record_id  <= request_queue[0].id;
            i_record_age <= request_queue[0].age;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: results are strobed for one cycle
    always @(posedge i_clk) begin
        t_queue_res want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("result with no request outstanding", 0, 1);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    flag_mismatch("status", want.status, o_status);
                if (o_place !== want.place)
                    flag_mismatch("place", want.place, o_place);
                if (o_wait_estimate !== want.wait_estimate)
                    flag_mismatch("wait_estimate", want.wait_estimate, o_wait_estimate);
                if (o_head_urgency !== want.head_urgency)
                    flag_mismatch("head_urgency", want.head_urgency, o_head_urgency);
                if (o_head_id !== want.head_id)
                    flag_mismatch("head_id", want.head_id, o_head_id);
                if (o_head_age !== want.head_age)
                    flag_mismatch("head_age", want.head_age, o_head_age);
                if (o_occupancy !== want.occupancy)
                    flag_mismatch("occupancy", want.occupancy, o_occupancy);
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_wr_en || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Timeout: no request or result for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned               phase_gap [5];
        logic [spq_pkg::MIN_W-1:0] phase_minutes [5];
        t_queue_req                r;
        int unsigned               ins_pct;
        int unsigned               urg;

        phase_gap     = '{0, 59, 0, 34, 0};
        phase_minutes = '{spq_pkg::MINUTES_RESET, 8'd255, 8'd0,
                          8'($urandom_range(1, 254)), 8'd1};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                wait (request_queue.size() == 0 && expected_results.size() == 0);
                repeat (3) @(posedge i_clk);
                write_minutes(phase_minutes[ph]);
            end
            gap_pct = phase_gap[ph];

            if (ph == 0) begin
                // pop on empty, extremes, equal-urgency ties, fill, insert on full
                r = make_insert(0, '0, 0);
                r.func = spq_pkg::FUNC_POP;
                request_queue.push_back(r);
                request_queue.push_back(make_insert(15, ID_MAX, 150));
                request_queue.push_back(make_insert(0, '0, 0));
                request_queue.push_back(make_insert(15, {1'b1, {(spq_pkg::ID_W-1){1'b0}}},
                                                    128));
                request_queue.push_back(make_insert(7, 54'h15_5555_5555_5555, 127));
                for (int i = 0; i < 12; i++)
                    request_queue.push_back(make_insert((i * 5) % 16, rand_id(),
                                                        $urandom_range(0, 150)));
                request_queue.push_back(make_insert(0, ID_MAX, 150));
                r.func = spq_pkg::FUNC_POP;
                repeat (3) request_queue.push_back(r);
                request_queue.push_back(make_insert(0, rand_id(), 1));
            end

            ins_pct = 50;
            for (int n = 0; n < RAND_PER_PH; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: ins_pct = 20;
                        1: ins_pct = 50;
                        default: ins_pct = 85;
                    endcase
                end
                // narrow urgency range in part of the requests to force ties
                urg = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(0, 15);
                r = make_insert(urg, rand_id(), $urandom_range(0, 150));
                if ($urandom_range(0, 99) >= ins_pct) r.func = spq_pkg::FUNC_POP;
                request_queue.push_back(r);
            end
        end

        wait (request_queue.size() == 0 && expected_results.size() == 0);
        repeat (4) @(posedge i_clk);

        $display("Covered %0d requests: %0d inserts (%0d rejected full), %0d pops (%0d on empty)",
                 requests_taken, insert_count, full_count, pop_count, empty_count);
        $display("Checked %0d results over 5 idle/minutes settings, peak occupancy %0d",
                 results_checked, max_held);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
